// ----- rtl/core/life_cellular_automaton_grid_top_assert.svh -----
// assertion macros for the life grid block
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef LIFE_CELLULAR_AUTOMATON_GRID_TOP_ASSERT_SVH
`define LIFE_CELLULAR_AUTOMATON_GRID_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define LIFECA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// expression must never be true out of reset
`define LIFECA_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`else

`define LIFECA_ASSERT(lbl, prop, msg)

`define LIFECA_NEVER(lbl, expr, msg)

`endif

`endif

// ----- rtl/core/lifeca_pkg.sv -----
// shared types and constants of the life grid block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lifeca_pkg;

  localparam int unsigned ROWS_DEF   = 64;
  localparam int unsigned COLS_DEF   = 64;

  localparam int unsigned OP_W       = 2;
  localparam int unsigned ROW_IDX_W  = 6;
  localparam int unsigned COL_IDX_W  = 6;
  localparam int unsigned ROW_BITS_W = 64;

  // slave tdata: cell_row, cell_col, padded to whole bytes
  localparam int unsigned S_TDATA_W  = 16;
  // master tdata: row_index, row_bits, padded to whole bytes
  localparam int unsigned M_TDATA_W  = 72;

  typedef enum logic [OP_W-1:0] {
    OP_SET   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_STEP  = 2'd3
  } op_e;

  // b3/s23 neighbour counts
  localparam logic [3:0] BIRTH_COUNT = 4'd3;
  localparam logic [3:0] KEEP_COUNT  = 4'd2;

endpackage

`default_nettype wire

// ----- rtl/core/lifeca_cell.sv -----
// one row cell of the grid chain, shifts towards the head when enabled
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

module lifeca_cell #(
  parameter int unsigned W = 64
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         shift_en_i,
  input  wire logic [W-1:0] d_i,
  output logic      [W-1:0] q_o
);

  logic [W-1:0] row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else if (shift_en_i) begin
      row_q <= d_i;
    end
  end

  assign q_o = row_q;

endmodule

`default_nettype wire

// ----- rtl/core/lifeca_rule.sv -----
// b3/s23 update of one row from the rows above and below it
// depends on lifeca_pkg
`timescale 1ns / 1ps
`default_nettype none

module lifeca_rule #(
  parameter int unsigned COLS = 64
) (
  input  wire logic [COLS-1:0] up_i,
  input  wire logic [COLS-1:0] mid_i,
  input  wire logic [COLS-1:0] dn_i,
  output logic      [COLS-1:0] nxt_o
);

  import lifeca_pkg::*;

  // dead guard column on each side
  logic [COLS+1:0] up_x;
  logic [COLS+1:0] mid_x;
  logic [COLS+1:0] dn_x;

  assign up_x  = {1'b0, up_i, 1'b0};
  assign mid_x = {1'b0, mid_i, 1'b0};
  assign dn_x  = {1'b0, dn_i, 1'b0};

  always_comb begin
    logic [3:0] cnt;
    cnt   = '0;
    nxt_o = '0;
    for (int c = 0; c < COLS; c++) begin
      cnt = 4'(up_x[c]) + 4'(up_x[c+1]) + 4'(up_x[c+2])
          + 4'(mid_x[c]) + 4'(mid_x[c+2])
          + 4'(dn_x[c]) + 4'(dn_x[c+1]) + 4'(dn_x[c+2]);
      nxt_o[c] = (cnt == BIRTH_COUNT) || ((cnt == KEEP_COUNT) && mid_i[c]);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/life_cellular_automaton_grid_top.sv -----
// life grid top level: a circular chain of row cells, one rule unit at the chain head
// set, clear, read: d rotations (d up to ROWS-1) bring the row to the head, SEEK sees it there,
//   APPLY edits it and loads the registered report, waiting while the held report is not taken
// advance: d rotations to row 0, then one new row per cycle while the report side is free
// out-of-range row: goes from accept straight to APPLY, no rotation, reports an all-zero row
// reset clears every cell at once, no clearing pass; needs lifeca_pkg, cell, rule, macros
`timescale 1ns / 1ps
`default_nettype none

`include "life_cellular_automaton_grid_top_assert.svh"

module life_cellular_automaton_grid_top #(
  parameter int unsigned ROWS = lifeca_pkg::ROWS_DEF,
  parameter int unsigned COLS = lifeca_pkg::COLS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // command transactions
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // [5:0] cell_row, [11:6] cell_col, [15:12] zero
  input  wire logic [lifeca_pkg::S_TDATA_W-1:0]   s_axis_tdata_i,
  // [1:0] opcode
  input  wire logic [lifeca_pkg::OP_W-1:0]        s_axis_tuser_i,
  // row report transactions
  output logic                                    m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  // [5:0] row_index, [69:6] row_bits, [71:70] zero
  output logic      [lifeca_pkg::M_TDATA_W-1:0]   m_axis_tdata_o,
  // last
  output logic                                    m_axis_tlast_o
);

  import lifeca_pkg::*;

  // width of the head offset, and a compare width that can hold ROWS itself
  localparam int unsigned RW = $clog2(ROWS);
  localparam int unsigned CW = ((RW > ROW_IDX_W) ? RW : ROW_IDX_W) + 1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SEEK  = 4'b0010,
    S_APPLY = 4'b0100,
    S_GEN   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // chain cell p holds grid row (p + offs_q) mod ROWS
  logic [RW-1:0]   offs_q, offs_d, offs_inc;
  logic [RW-1:0]   tgt_q, tgt_d;
  logic [COLS-1:0] prev_q, prev_d;
  logic            at_end;

  // latched command
  op_e                  op_q;
  logic [ROW_IDX_W-1:0] row_in_q;
  logic [COL_IDX_W-1:0] col_q;
  logic                 oor_q;

  // chain of row cells
  logic [COLS-1:0] grid [ROWS];
  logic [COLS-1:0] chain_in;
  logic            shift_en;
  logic [COLS-1:0] head;
  logic [COLS-1:0] below;
  logic [COLS-1:0] gen_row;
  logic [COLS-1:0] edited;
  logic [COLS-1:0] bit_mask;

  // output register
  logic                  out_vld_q, out_vld_d;
  logic [ROW_IDX_W-1:0]  out_idx_q, out_idx_d;
  logic [ROW_BITS_W-1:0] out_bits_q, out_bits_d;
  logic                  out_last_q, out_last_d;
  logic                  out_free;
  logic                  out_ld;

  // input side
  op_e                  in_op;
  logic [ROW_IDX_W-1:0] in_row;
  logic [COL_IDX_W-1:0] in_col;
  logic                 in_acc;
  logic                 in_oor;

  assign in_op  = op_e'(s_axis_tuser_i);
  assign in_row = s_axis_tdata_i[ROW_IDX_W-1:0];
  assign in_col = s_axis_tdata_i[ROW_IDX_W +: COL_IDX_W];
  assign in_oor = (CW'(in_row) >= CW'(ROWS));

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  for (genvar p = 0; p < ROWS; p++) begin : g_chain
    logic [COLS-1:0] cell_d;
    if (p == ROWS - 1) begin : g_tail
      assign cell_d = chain_in;
    end else begin : g_body
      assign cell_d = grid[p+1];
    end
    lifeca_cell #(
      .W (COLS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_en_i (shift_en),
      .d_i        (cell_d),
      .q_o        (grid[p])
    );
  end

  assign head     = grid[0];
  assign at_end   = (offs_q == RW'(ROWS - 1));
  assign offs_inc = at_end ? '0 : offs_q + 1'b1;
  // by the last row the cell behind the head already holds new row 0, and
  // below the last row everything is dead anyway
  assign below    = at_end ? '0 : grid[1];

  lifeca_rule #(
    .COLS (COLS)
  ) u_rule (
    .up_i  (prev_q),
    .mid_i (head),
    .dn_i  (below),
    .nxt_o (gen_row)
  );

  // a column beyond the grid shifts out and leaves the mask empty
  assign bit_mask = COLS'(1) << col_q;

  always_comb begin
    unique case (op_q)
      OP_SET:   edited = head | bit_mask;
      OP_CLEAR: edited = head & ~bit_mask;
      default:  edited = head;
    endcase
  end

  assign out_free = !out_vld_q || m_axis_tready_i;

  always_comb begin
    state_d    = state_q;
    offs_d     = offs_q;
    tgt_d      = tgt_q;
    prev_d     = prev_q;
    shift_en   = 1'b0;
    chain_in   = head;
    out_ld     = 1'b0;
    out_idx_d  = out_idx_q;
    out_bits_d = out_bits_q;
    out_last_d = out_last_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_op == OP_STEP) begin
            tgt_d   = '0;
            state_d = S_SEEK;
          end else if (in_oor) begin
            state_d = S_APPLY;
          end else begin
            tgt_d   = RW'(in_row);
            state_d = S_SEEK;
          end
        end
      end
      S_SEEK: begin
        if (offs_q == tgt_q) begin
          prev_d  = '0;
          state_d = (op_q == OP_STEP) ? S_GEN : S_APPLY;
        end else begin
          // plain rotation, head goes round to the tail
          shift_en = 1'b1;
          chain_in = head;
          offs_d   = offs_inc;
        end
      end
      S_APPLY: begin
        if (out_free) begin
          out_ld     = 1'b1;
          out_idx_d  = row_in_q;
          out_last_d = 1'b1;
          if (oor_q) begin
            out_bits_d = '0;
          end else begin
            out_bits_d = ROW_BITS_W'(edited);
            shift_en   = 1'b1;
            chain_in   = edited;
            offs_d     = offs_inc;
          end
          state_d = S_IDLE;
        end
      end
      S_GEN: begin
        if (out_free) begin
          out_ld     = 1'b1;
          out_idx_d  = ROW_IDX_W'(offs_q);
          out_bits_d = ROW_BITS_W'(gen_row);
          out_last_d = at_end;
          shift_en   = 1'b1;
          chain_in   = gen_row;
          // keep the old row for the next row's upper neighbours
          prev_d     = head;
          offs_d     = offs_inc;
          if (at_end) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_ld) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      offs_q    <= '0;
      tgt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      offs_q    <= offs_d;
      tgt_q     <= tgt_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    prev_q     <= prev_d;
    out_idx_q  <= out_idx_d;
    out_bits_q <= out_bits_d;
    out_last_q <= out_last_d;
    if (in_acc) begin
      op_q     <= in_op;
      row_in_q <= in_row;
      col_q    <= in_col;
      oor_q    <= in_oor && (in_op != OP_STEP);
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{(M_TDATA_W - ROW_BITS_W - ROW_IDX_W){1'b0}}, out_bits_q, out_idx_q};
  assign m_axis_tlast_o  = out_last_q;

  `LIFECA_NEVER(a_no_overwrite, out_ld && out_vld_q && !m_axis_tready_i, "output register overwritten")
  `LIFECA_NEVER(a_offs_range, offs_q > RW'(ROWS - 1), "head offset beyond last row")
  `LIFECA_ASSERT(a_gen_ends, (state_q == S_GEN && out_ld && at_end) |=> (state_q == S_IDLE), "generation did not end after last row")
  `LIFECA_ASSERT(a_one_cmd, in_acc |=> !s_axis_tready_o, "second command taken while busy")

endmodule

`default_nettype wire
